// ----- rtl/core/bsd_pkg.sv -----
// bsd_pkg: shared constants and helpers for the binary search divider.
// Used by binary_search_divider and its checker; depends on nothing.
package bsd_pkg;

   // Input register, one restoring step per quotient bit, output register.
   function automatic int pipe_latency(input int data_width);
      return data_width + 2;
   endfunction

endpackage

// ----- rtl/core/binary_search_divider.sv -----
// binary_search_divider: signed integer divider, truncating toward zero.
// Fully pipelined restoring divider; depends on bsd_pkg.
//
// Usage:
//   An item (req_dividend, req_divisor) is taken at a rising edge with start
//   high and busy low. busy is only high in the cycle after a reset cycle, so
//   a new item may be issued every cycle.
//   Each item gives one quotient on rsp_quotient, marked by rsp_valid for a
//   single cycle, after it passes the input register, DATA_WIDTH restoring
//   stages of one quotient bit each and the output register.
//   Throughput is one item per cycle while busy is low; the depth is set by the chain of
//   DATA_WIDTH compare-and-subtract stages, one per quotient bit.
//   The receiver cannot stall: rsp_valid must be taken when it is shown.
//   A zero dividend gives 0; a zero divisor gives minus |dividend|.
//   The quotient has one bit more than the operands, so the most negative
//   dividend over -1 is exact.
//   Reset clears every stage's valid bit; items in flight are dropped.
module binary_search_divider #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_dividend,
   input  logic signed [DATA_WIDTH-1:0] req_divisor,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH:0]   rsp_quotient
);
   import bsd_pkg::*;

   localparam int STEPS = pipe_latency(DATA_WIDTH) - 2;

   logic                  busy_ff;
   logic                  valid_ff [0:STEPS];
   logic                  neg_ff   [0:STEPS];
   logic [DATA_WIDTH-1:0] rem_ff   [0:STEPS];
   logic [DATA_WIDTH-1:0] quo_ff   [0:STEPS];
   logic [DATA_WIDTH-1:0] div_ff   [0:STEPS];

   logic                  a_neg, b_neg, neg_in;
   logic [DATA_WIDTH-1:0] ma, mb, div_in;
   logic                  out_valid_ff;
   logic [DATA_WIDTH:0]   q_ext, out_quotient_ff, out_quotient_in;

   always_ff @(posedge clock) begin
      busy_ff <= reset;
   end

   assign busy = busy_ff;

   // input stage: magnitudes and result sign; a zero divisor becomes one
   always_comb begin
      a_neg  = req_dividend[DATA_WIDTH-1];
      b_neg  = req_divisor[DATA_WIDTH-1];
      ma     = a_neg ? (~req_dividend + 1'b1) : req_dividend;
      mb     = b_neg ? (~req_divisor + 1'b1) : req_divisor;
      div_in = (mb == '0) ? DATA_WIDTH'(1) : mb;
      neg_in = !((req_dividend != '0) && (req_divisor != '0) && (a_neg == b_neg));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else begin
         valid_ff[0] <= start && !busy_ff;
      end
      neg_ff[0] <= neg_in;
      rem_ff[0] <= '0;
      quo_ff[0] <= ma;
      div_ff[0] <= div_in;
   end

   for (genvar k = 1; k <= STEPS; k++) begin : g_step
      logic [DATA_WIDTH:0]   trial;
      logic                  borrow;
      logic [DATA_WIDTH-1:0] rem_in, quo_in;

      always_comb begin
         trial  = {rem_ff[k-1], quo_ff[k-1][DATA_WIDTH-1]} - {1'b0, div_ff[k-1]};
         borrow = trial[DATA_WIDTH];
         rem_in = borrow ? {rem_ff[k-1][DATA_WIDTH-2:0], quo_ff[k-1][DATA_WIDTH-1]}
                         : trial[DATA_WIDTH-1:0];
         quo_in = {quo_ff[k-1][DATA_WIDTH-2:0], ~borrow};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_ff[k-1];
         end
         neg_ff[k] <= neg_ff[k-1];
         rem_ff[k] <= rem_in;
         quo_ff[k] <= quo_in;
         div_ff[k] <= div_ff[k-1];
      end
   end

   always_comb begin
      q_ext           = {1'b0, quo_ff[STEPS]};
      out_quotient_in = neg_ff[STEPS] ? (~q_ext + 1'b1) : q_ext;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= valid_ff[STEPS];
      end
      out_quotient_ff <= out_quotient_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_quotient = out_quotient_ff;

endmodule

// ----- rtl/core/bsd_checker.sv -----
// bsd_checker: port-level assertions for binary_search_divider, with bind.
// Depends on bsd_pkg for the pipeline latency.
module bsd_checker #(
   parameter int DATA_WIDTH = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         start,
   input logic                         busy,
   input logic signed [DATA_WIDTH-1:0] req_dividend,
   input logic signed [DATA_WIDTH-1:0] req_divisor,
   input logic                         rsp_valid,
   input logic signed [DATA_WIDTH:0]   rsp_quotient
);
   import bsd_pkg::*;

   localparam int LAT = pipe_latency(DATA_WIDTH);

   logic accept;
   assign accept = start && !busy;

   a_busy_only_after_reset: assert property (@(posedge clock)
      !reset |=> !busy) else $error("busy high without reset");

   a_item_answered: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LAT rsp_valid) else $error("item lost in pipeline");

   a_no_invented_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LAT)) else $error("result without item");

   a_zero_dividend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && (req_dividend == '0), LAT)) |-> (rsp_quotient == '0))
      else $error("zero dividend gave nonzero quotient");

   // dividing by one hands back the dividend, sign-extended
   a_unit_divisor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(accept && (req_divisor == 1), LAT))
         |-> (rsp_quotient == $past({req_dividend[DATA_WIDTH-1], req_dividend}, LAT)))
      else $error("division by one changed the dividend");

endmodule

bind binary_search_divider bsd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_bsd_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .req_dividend (req_dividend),
   .req_divisor  (req_divisor),
   .rsp_valid    (rsp_valid),
   .rsp_quotient (rsp_quotient)
);
